// ===== rtl/mlpv_pkg.sv =====
// Package for the patch-voting perceptron block: sizes, codes, payload and token types.
// Holds the sum finishing function used by the network engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlpv_pkg;

   // Network sizes
   localparam int MAX_NODES   = 256;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int CNT_W       = NODE_W + 1;
   localparam int MAX_CLASSES = 64;
   localparam int CLS_W       = $clog2(MAX_CLASSES);
   localparam int NOUT_W      = CLS_W + 1;
   localparam int NUM_SLOTS   = 3;
   localparam int SLOT_W      = 2;
   localparam int FRAC_BITS   = 8;
   localparam int VAL_W       = 16;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int ACC_W       = PROD_W + NODE_W + 2;
   localparam int VOTE_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = CNT_W;

   // Item commands
   typedef enum logic [1:0] {
      CMD_WEIGHT  = 2'd0,
      CMD_BIAS    = 2'd1,
      CMD_FEATURE = 2'd2,
      CMD_IMAGE   = 2'd3
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_INPUTS    = 3'd0,
      CSR_NUM_HIDDEN    = 3'd1,
      CSR_NUM_HIDDEN2   = 3'd2,
      CSR_NUM_OUTPUTS   = 3'd3,
      CSR_TWO_HIDDEN    = 3'd4
   } csr_index_type;

   // Result kinds
   localparam logic KIND_VOTE  = 1'b0;
   localparam logic KIND_IMAGE = 1'b1;

   typedef struct packed {
      cmd_type                  cmd;
      logic [1:0]               layer;
      logic [7:0]               src_index;
      logic [7:0]               dst_index;
      logic signed [VAL_W-1:0]  value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [5:0]        class_index;
      logic [VOTE_W-1:0] vote_count;
   } rsp_type;

   // Clamped layer sizes
   typedef struct packed {
      logic [CNT_W-1:0]  nin;
      logic [CNT_W-1:0]  nh1;
      logic [CNT_W-1:0]  nh2;
      logic [NOUT_W-1:0] nout;
      logic              two;
   } cfg_type;

   // Token walking the histogram row
   typedef struct packed {
      logic              valid;
      logic              image;
      logic [CLS_W-1:0]  cls;
      logic [VOTE_W-1:0] cnt;
   } token_type;

   // Floor shift, saturate, optional ReLU
   function automatic logic signed [VAL_W-1:0] finish_sum(
      input logic signed [ACC_W-1:0] acc,
      input logic                    relu
   );
      logic signed [ACC_W-1:0] sh;
      logic signed [ACC_W-1:0] res;
      sh  = acc >>> FRAC_BITS;
      res = sh;
      if (sh > ACC_W'(32767)) res = ACC_W'(32767);
      if (sh < -ACC_W'(32768)) res = -ACC_W'(32768);
      if (relu && res < 0) res = '0;
      return VAL_W'(res);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mlpv_cell.sv =====
// One histogram cell: holds the vote count of one class and passes the token on.
// Depends on mlpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpv_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [mlpv_pkg::CLS_W-1:0]  cell_index,
   input  wire logic [mlpv_pkg::NOUT_W-1:0] nout,
   input  wire mlpv_pkg::token_type       tok_in,
   output mlpv_pkg::token_type            tok_out
);
   import mlpv_pkg::*;

   logic [VOTE_W-1:0] count_ff, count_in;
   token_type         tok_ff, tok_in_nxt;

   // Vote: bump own count on a match. Image: compete and clear.
   always_comb begin
      count_in   = count_ff;
      tok_in_nxt = tok_in;
      if (tok_in.valid) begin
         if (tok_in.image) begin
            if ({1'b0, cell_index} < nout && count_ff > tok_in.cnt) begin
               tok_in_nxt.cnt = count_ff;
               tok_in_nxt.cls = cell_index;
            end
            count_in = '0;
         end else if (tok_in.cls == cell_index) begin
            if (count_ff != {VOTE_W{1'b1}}) count_in = count_ff + 1'b1;
            tok_in_nxt.cnt = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tok_ff   <= '0;
      end else begin
         count_ff <= count_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== rtl/mlpv_chain.sv =====
// Row of histogram cells; a token advances one cell per cycle.
// Depends on mlpv_pkg and mlpv_cell.
`timescale 1ns / 1ps
`default_nettype none

module mlpv_chain (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [mlpv_pkg::NOUT_W-1:0] nout,
   input  wire mlpv_pkg::token_type       launch,
   output mlpv_pkg::token_type            tok_last
);
   import mlpv_pkg::*;

   token_type tok [MAX_CLASSES];

   for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
      if (k == 0) begin : g_first
         mlpv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (CLS_W'(k)),
            .nout       (nout),
            .tok_in     (launch),
            .tok_out    (tok[k])
         );
      end else begin : g_rest
         mlpv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (CLS_W'(k)),
            .nout       (nout),
            .tok_in     (tok[k-1]),
            .tok_out    (tok[k])
         );
      end
   end

   assign tok_last = tok[MAX_CLASSES-1];

endmodule

`default_nettype wire

// ===== rtl/mlpv_engine.sv =====
// Network engine: weight, bias and activation memories and one pipelined MAC.
// Walks every layer neuron by neuron and keeps the running argmax of the outputs.
// Depends on mlpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpv_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mlpv_pkg::cfg_type        cfg,
   input  wire logic                     req_fire,
   input  wire mlpv_pkg::req_type        req,
   output logic                          idle,
   output logic                          done,
   output logic [mlpv_pkg::CLS_W-1:0]    best_cls
);
   import mlpv_pkg::*;

   localparam int WADDR_W = $clog2(NUM_SLOTS * MAX_NODES * MAX_NODES);
   localparam int BADDR_W = $clog2(NUM_SLOTS * MAX_NODES);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_BIAS  = 5'b00010,
      S_MAC   = 5'b00100,
      S_DRAIN = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   // Memories
   logic signed [VAL_W-1:0] wgt_mem  [NUM_SLOTS*MAX_NODES*MAX_NODES];
   logic signed [VAL_W-1:0] bias_mem [NUM_SLOTS*MAX_NODES];
   logic signed [VAL_W-1:0] act_mem  [NUM_SLOTS*MAX_NODES];

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        dst_ff, dst_in;
   logic [CNT_W-1:0]        src_ff, src_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0] act_rd_ff, wgt_rd_ff, bias_rd_ff;
   logic                    load_bias_ff;
   logic                    v1_ff, last1_ff, v2_ff, last2_ff, done3_ff;
   logic                    done_ff, done_in;
   logic [CLS_W-1:0]        best_cls_ff, best_cls_in;
   logic signed [VAL_W-1:0] best_val_ff, best_val_in;

   logic                    is_out, issue, issue_last;
   logic [CNT_W-1:0]        nsrc, ndst;
   logic signed [VAL_W-1:0] neuron_val;
   logic [WADDR_W-1:0]      wgt_waddr, wgt_raddr;
   logic [BADDR_W-1:0]      bias_waddr, bias_raddr, act_waddr, act_raddr;
   logic                    act_we;
   logic signed [VAL_W-1:0] act_wdata;

   // Layer geometry for the current slot
   always_comb begin
      is_out = (slot_ff == 2'd2) || (slot_ff == 2'd1 && !cfg.two);
      case (slot_ff)
         2'd0:    nsrc = cfg.nin;
         2'd1:    nsrc = cfg.nh1;
         default: nsrc = cfg.nh2;
      endcase
      if (is_out)             ndst = CNT_W'(cfg.nout);
      else if (slot_ff == '0) ndst = cfg.nh1;
      else                    ndst = cfg.nh2;
   end

   assign issue      = (state_ff == S_MAC);
   assign issue_last = issue && (src_ff == nsrc - 1'b1);
   assign neuron_val = finish_sum(acc_ff, !is_out);

   // Memory addressing
   assign wgt_waddr  = {req.layer, req.src_index, req.dst_index};
   assign bias_waddr = {req.layer, req.dst_index};
   assign wgt_raddr  = {slot_ff, src_ff[NODE_W-1:0], dst_ff[NODE_W-1:0]};
   assign bias_raddr = {slot_ff, dst_ff[NODE_W-1:0]};
   assign act_raddr  = {slot_ff, src_ff[NODE_W-1:0]};

   // Activation write: feature element from the port or a hidden unit result
   always_comb begin
      act_we    = 1'b0;
      act_waddr = {2'd0, req.src_index};
      act_wdata = req.value;
      if (req_fire && req.cmd == CMD_FEATURE) begin
         act_we = 1'b1;
      end else if (state_ff == S_WRITE && !is_out) begin
         act_we    = 1'b1;
         act_waddr = {slot_ff + 2'd1, dst_ff[NODE_W-1:0]};
         act_wdata = neuron_val;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req.cmd == CMD_WEIGHT && req.layer != 2'd3) begin
         wgt_mem[wgt_waddr] <= req.value;
      end
      if (req_fire && req.cmd == CMD_BIAS && req.layer != 2'd3) begin
         bias_mem[bias_waddr] <= req.value;
      end
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      wgt_rd_ff  <= wgt_mem[wgt_raddr];
      bias_rd_ff <= bias_mem[bias_raddr];
      act_rd_ff  <= act_mem[act_raddr];
      prod_ff    <= act_rd_ff * wgt_rd_ff;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      dst_in      = dst_ff;
      src_in      = src_ff;
      done_in     = 1'b0;
      best_cls_in = best_cls_ff;
      best_val_in = best_val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req.cmd == CMD_FEATURE && req.last_element) begin
               slot_in  = '0;
               dst_in   = '0;
               state_in = S_BIAS;
            end
         end
         S_BIAS: begin
            src_in   = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            src_in = src_ff + 1'b1;
            if (issue_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (done3_ff) state_in = S_WRITE;
         end
         S_WRITE: begin
            if (is_out && (dst_ff == '0 || neuron_val > best_val_ff)) begin
               best_cls_in = dst_ff[CLS_W-1:0];
               best_val_in = neuron_val;
            end
            state_in = S_BIAS;
            if (dst_ff == ndst - 1'b1) begin
               dst_in = '0;
               if (is_out) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end else begin
               dst_in = dst_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Accumulator: bias first, then one product per cycle
   always_comb begin
      acc_in = acc_ff;
      if (load_bias_ff) acc_in = ACC_W'(bias_rd_ff) <<< FRAC_BITS;
      else if (v2_ff)   acc_in = acc_ff + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_bias_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         done3_ff     <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_bias_ff <= (state_ff == S_BIAS);
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         done3_ff     <= v2_ff && last2_ff;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      dst_ff      <= dst_in;
      src_ff      <= src_in;
      acc_ff      <= acc_in;
      last1_ff    <= issue_last;
      last2_ff    <= last1_ff;
      best_cls_ff <= best_cls_in;
      best_val_ff <= best_val_in;
   end

   assign idle     = (state_ff == S_IDLE) && !done_ff;
   assign done     = done_ff;
   assign best_cls = best_cls_ff;

endmodule

`default_nettype wire

// ===== rtl/mlp_relu_inference_vote_top.sv =====
// Top level of the patch-voting perceptron: configuration registers, engine,
// histogram row and result register. Depends on mlpv_pkg, mlpv_engine, mlpv_chain.
//
// Usage:
//  req channel (valid/ready, payload req_data): weight and bias writes, feature
//   elements and end-of-image items. Weight, bias and plain feature writes
//   give no result.
//  A feature element with last_element set starts the network. One MAC walks
//   the layers; each neuron loads its bias, accumulates over its fan-in, drains
//   the MAC pipeline and writes back; after the last output neuron the vote
//   walks the histogram row before the rsp transfer.
//  An end-of-image item passes through the row of histogram cells to rsp and
//   clears the histogram on its way.
//  rsp channel (valid/ready, payload rsp_data) is a held output register; while
//   a result waits, req_ready stays low.
//  csr port: write enable, index, data; write only while idle.
//  Reset (synchronous) clears the histogram, the handshakes and the configuration registers
//   to their defaults; memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module mlp_relu_inference_vote_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire mlpv_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output mlpv_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [mlpv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mlpv_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mlpv_pkg::*;

   logic [CNT_W-1:0]  nin_ff, nh1_ff, nh2_ff;
   logic [NOUT_W-1:0] nout_ff;
   logic              two_ff;
   cfg_type           cfg;
   logic              req_fire, eng_idle, eng_done, busy_ff, busy_in;
   logic [CLS_W-1:0]  eng_cls;
   token_type         launch, tok_last;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nin_ff  <= CNT_W'(256);
         nh1_ff  <= CNT_W'(64);
         nh2_ff  <= CNT_W'(64);
         nout_ff <= NOUT_W'(10);
         two_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_INPUTS:  nin_ff  <= csr_wdata;
            CSR_NUM_HIDDEN:  nh1_ff  <= csr_wdata;
            CSR_NUM_HIDDEN2: nh2_ff  <= csr_wdata;
            CSR_NUM_OUTPUTS: nout_ff <= csr_wdata[NOUT_W-1:0];
            CSR_TWO_HIDDEN:  two_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp sizes into range
   function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CNT_W-1:0] v);
      if (v == '0) return CNT_W'(1);
      if (v > CNT_W'(MAX_NODES)) return CNT_W'(MAX_NODES);
      return v;
   endfunction

   always_comb begin
      cfg.nin  = clamp_nodes(nin_ff);
      cfg.nh1  = clamp_nodes(nh1_ff);
      cfg.nh2  = clamp_nodes(nh2_ff);
      cfg.two  = two_ff;
      cfg.nout = nout_ff;
      if (nout_ff == '0) cfg.nout = NOUT_W'(1);
      else if (nout_ff > NOUT_W'(MAX_CLASSES)) cfg.nout = NOUT_W'(MAX_CLASSES);
   end

   assign req_ready = eng_idle && !busy_ff && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   mlpv_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_fire (req_fire),
      .req      (req_data),
      .idle     (eng_idle),
      .done     (eng_done),
      .best_cls (eng_cls)
   );

   // Token into the histogram row: vote from the engine or end of image
   always_comb begin
      launch = '0;
      if (eng_done) begin
         launch.valid = 1'b1;
         launch.image = 1'b0;
         launch.cls   = eng_cls;
      end else if (req_fire && req_data.cmd == CMD_IMAGE) begin
         launch.valid = 1'b1;
         launch.image = 1'b1;
      end
   end

   mlpv_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .nout     (cfg.nout),
      .launch   (launch),
      .tok_last (tok_last)
   );

   // Row occupancy and result register
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (launch.valid)             busy_in = 1'b1;
      else if (tok_last.valid)      busy_in = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (tok_last.valid)           rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_last.valid) begin
         rsp_ff.kind        <= tok_last.image ? KIND_IMAGE : KIND_VOTE;
         rsp_ff.class_index <= 6'(tok_last.cls);
         rsp_ff.vote_count  <= tok_last.cnt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/mlpv_checker.sv =====
// Port-level checker for the perceptron top level, bound to it below.
// Depends on mlpv_pkg and mlp_relu_inference_vote_top.
`timescale 1ns / 1ps
`default_nettype none

module mlpv_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire mlpv_pkg::req_type    req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire mlpv_pkg::rsp_type    rsp_data
);
   import mlpv_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // Input is held off while a result waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req accepted with result pending");

   // End of image comes out after the histogram row
   a_image_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == CMD_IMAGE
      |-> ##(MAX_CLASSES + 1) rsp_valid && rsp_data.kind == KIND_IMAGE)
      else $error("image result late or wrong kind");

   // A patch vote always counts at least its own vote
   a_vote_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_VOTE |-> rsp_data.vote_count != '0)
      else $error("patch vote with zero count");

endmodule

bind mlp_relu_inference_vote_top mlpv_checker u_mlpv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/mlp_relu_inference_vote_top_tb.sv =====
// Testbench for mlp_relu_inference_vote_top: directed and random item streams with a
// built-in network predictor and in-order result checking.
// Depends on mlpv_pkg and the RTL of mlp_relu_inference_vote_top.
`timescale 1ns / 1ps

module mlp_relu_inference_vote_top_tb;
   import mlpv_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mlp_relu_inference_vote_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Predictor state
   shortint weight_mem[NUM_SLOTS][MAX_NODES][MAX_NODES];
   shortint bias_mem[NUM_SLOTS][MAX_NODES];
   shortint feature_mem[MAX_NODES];
   int unsigned votes[MAX_CLASSES];
   int cfg_nin = 256, cfg_nh1 = 64, cfg_nh2 = 64, cfg_nout = 10, cfg_two = 0;

   rsp_type class_queue[$];
   int mismatches = 0;
   int hold_off = 0;
   int rsp_gap = 0;
   bit no_gaps = 1'b0;
   int idle_count = 0;

   function automatic int clamp_size(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Floor shift, saturate, optional ReLU
   function automatic shortint finish_neuron(longint acc, bit relu);
      longint r;
      r = acc >>> FRAC_BITS;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      if (relu && r < 0) r = 0;
      return shortint'(r);
   endfunction

   function automatic void eval_layer(int slot, input shortint src[MAX_NODES], int nsrc,
                                      output shortint dst[MAX_NODES], input int ndst,
                                      input bit relu);
      longint acc;
      for (int i = 0; i < MAX_NODES; i++) dst[i] = 0;
      for (int i = 0; i < ndst; i++) begin
         acc = longint'(bias_mem[slot][i]) * 256;
         for (int j = 0; j < nsrc; j++)
            acc += longint'(src[j]) * longint'(weight_mem[slot][j][i]);
         dst[i] = finish_neuron(acc, relu);
      end
   endfunction

   function automatic int winning_class();
      shortint h1[MAX_NODES], h2[MAX_NODES], outv[MAX_NODES];
      int nin, nh1, nh2, nout, best;
      nin  = clamp_size(cfg_nin, MAX_NODES);
      nh1  = clamp_size(cfg_nh1, MAX_NODES);
      nh2  = clamp_size(cfg_nh2, MAX_NODES);
      nout = clamp_size(cfg_nout, MAX_CLASSES);
      eval_layer(0, feature_mem, nin, h1, nh1, 1'b1);
      if (cfg_two[0]) begin
         eval_layer(1, h1, nh1, h2, nh2, 1'b1);
         eval_layer(2, h2, nh2, outv, nout, 1'b0);
      end else begin
         eval_layer(1, h1, nh1, outv, nout, 1'b0);
      end
      best = 0;
      for (int i = 1; i < nout; i++)
         if (outv[i] > outv[best]) best = i;
      return best;
   endfunction

   // Update the predictor for one accepted transfer
   function automatic void predict_item(req_type r);
      rsp_type e;
      int cls, nout;
      case (r.cmd)
         CMD_WEIGHT:
            if (r.layer < NUM_SLOTS)
               weight_mem[r.layer][r.src_index][r.dst_index] = r.value;
         CMD_BIAS:   if (r.layer < NUM_SLOTS) bias_mem[r.layer][r.dst_index] = r.value;
         CMD_FEATURE: begin
            feature_mem[r.src_index] = r.value;
            if (r.last_element) begin
               cls = winning_class();
               if (votes[cls] < 65535) votes[cls]++;
               e.kind = KIND_VOTE;
               e.class_index = 6'(cls);
               e.vote_count = 16'(votes[cls]);
               class_queue.push_back(e);
            end
         end
         default: begin
            nout = clamp_size(cfg_nout, MAX_CLASSES);
            e.kind = KIND_IMAGE;
            e.class_index = '0;
            e.vote_count = '0;
            for (int i = 0; i < nout; i++)
               if (votes[i] > e.vote_count) begin
                  e.vote_count = 16'(votes[i]);
                  e.class_index = 6'(i);
               end
            for (int i = 0; i < MAX_CLASSES; i++) votes[i] = 0;
            class_queue.push_back(e);
         end
      endcase
   endfunction

   function automatic int random_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Values: full range, small multiples (ties), or extremes
   function automatic shortint random_value();
      int p;
      p = $urandom_range(9);
      if (p < 5) return shortint'($urandom);
      if (p < 8) return shortint'(($urandom_range(8) - 4) * 64);
      return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
   endfunction

   // Send one item; called at a rising edge, returns at one
   task automatic send_item(req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(r);
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(cmd_type c, int lyr, int src, int dst, shortint v, bit last);
      req_type r;
      r.cmd = c;
      r.layer = 2'(lyr);
      r.src_index = 8'(src);
      r.dst_index = 8'(dst);
      r.value = v;
      r.last_element = last;
      send_item(r);
   endtask

   // Wait for every result, then let the block settle
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (class_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NUM_INPUTS:  cfg_nin  = val & 'h1ff;
         CSR_NUM_HIDDEN:  cfg_nh1  = val & 'h1ff;
         CSR_NUM_HIDDEN2: cfg_nh2  = val & 'h1ff;
         CSR_NUM_OUTPUTS: cfg_nout = val & 'h7f;
         default:         cfg_two  = val & 1;
      endcase
   endtask

   task automatic set_network(int nin, int nh1, int nh2, int nout, int two);
      write_csr(CSR_NUM_INPUTS, nin);
      write_csr(CSR_NUM_HIDDEN, nh1);
      write_csr(CSR_NUM_HIDDEN2, nh2);
      write_csr(CSR_NUM_OUTPUTS, nout);
      write_csr(CSR_TWO_HIDDEN, two);
   endtask

   // Load every weight and bias the current sizes read, layer by layer and unit by unit
   task automatic load_network();
      int n[4];
      int layers;
      n[0] = clamp_size(cfg_nin, MAX_NODES);
      n[1] = clamp_size(cfg_nh1, MAX_NODES);
      if (cfg_two[0]) begin
         n[2] = clamp_size(cfg_nh2, MAX_NODES);
         n[3] = clamp_size(cfg_nout, MAX_CLASSES);
         layers = 3;
      end else begin
         n[2] = clamp_size(cfg_nout, MAX_CLASSES);
         layers = 2;
      end
      for (int l = 0; l < layers; l++) begin
         for (int d = 0; d < n[l+1]; d++) begin
            send_fields(CMD_BIAS, l, $urandom_range(255), d, random_value(), $urandom_range(1));
            for (int s = 0; s < n[l]; s++)
               send_fields(CMD_WEIGHT, l, s, d, random_value(), $urandom_range(1));
         end
      end
   endtask

   task automatic send_patch();
      int nin;
      nin = clamp_size(cfg_nin, MAX_NODES);
      for (int s = 0; s < nin; s++)
         send_fields(CMD_FEATURE, $urandom_range(3), s, $urandom_range(255), random_value(),
                     s == nin - 1);
   endtask

   // Smallest network, extremes of fields, ignored writes, empty histogram
   task automatic test_directed();
      set_network(0, 1, 0, 0, 0);
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      send_fields(CMD_WEIGHT, 0, 0, 0, 16'sh7fff, 1'b0);
      send_fields(CMD_BIAS, 0, 255, 0, 16'sh7fff, 1'b1);
      send_fields(CMD_WEIGHT, 1, 0, 0, 16'sh8000, 1'b0);
      send_fields(CMD_BIAS, 1, 0, 0, 16'sh0100, 1'b0);
      send_fields(CMD_WEIGHT, 3, 0, 0, 16'sh1234, 1'b0);
      send_fields(CMD_BIAS, 3, 0, 0, 16'sh4321, 1'b0);
      send_fields(CMD_FEATURE, 0, 0, 0, 16'sh7fff, 1'b1);
      send_fields(CMD_FEATURE, 0, 0, 0, 16'sh8000, 1'b1);
      send_fields(CMD_FEATURE, 0, 255, 0, 16'sh0001, 1'b0);
      send_fields(CMD_FEATURE, 3, 255, 255, 16'shffff, 1'b1);
      send_fields(CMD_IMAGE, 3, 255, 255, 16'sh7fff, 1'b1);
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Widest input layer, narrowest everything else
   task automatic test_wide_inputs();
      set_network(511, 0, 1, 1, 0);
      load_network();
      send_patch();
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Largest class count, with ties
   task automatic test_wide_outputs();
      set_network(1, 1, 1, 127, 0);
      load_network();
      repeat (4) send_patch();
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
      write_csr(CSR_NUM_OUTPUTS, 64);
      repeat (3) send_patch();
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Two hidden layers with a wider second layer
   task automatic test_two_hidden_wide();
      set_network(1, 1, 20, 2, 1);
      load_network();
      repeat (3) send_patch();
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Receiver holds off while the sender keeps offering patches
   task automatic test_backpressure();
      set_network(2, 3, 2, 4, 1);
      load_network();
      drain();
      hold_off = 400;
      for (int i = 0; i < 8; i++) send_patch();
      send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
      drain();
   endtask

   // Random phases: small random networks, then a mixed stream
   task automatic test_random();
      int p;
      for (int ph = 0; ph < 3; ph++) begin
         no_gaps = (ph == 1);
         set_network($urandom_range(6), $urandom_range(5), $urandom_range(5),
                     $urandom_range(8), $urandom_range(1));
         load_network();
         send_patch();
         for (int i = 0; i < 15; i++) begin
            p = $urandom_range(99);
            if (p < 55)
               send_fields(CMD_FEATURE, $urandom_range(3),
                           $urandom_range(clamp_size(cfg_nin, MAX_NODES) - 1),
                           $urandom_range(255), random_value(), $urandom_range(3) == 0);
            else if (p < 65)
               send_fields(CMD_FEATURE, $urandom_range(3), $urandom_range(255),
                           $urandom_range(255), random_value(), 1'b0);
            else if (p < 80)
               send_fields(CMD_WEIGHT, $urandom_range(3), $urandom_range(255),
                           $urandom_range(255), random_value(), $urandom_range(1));
            else if (p < 92)
               send_fields(CMD_BIAS, $urandom_range(3), $urandom_range(255),
                           $urandom_range(255), random_value(), $urandom_range(1));
            else
               send_fields(CMD_IMAGE, $urandom_range(3), $urandom_range(255),
                           $urandom_range(255), random_value(), $urandom_range(1));
         end
         send_fields(CMD_IMAGE, 0, 0, 0, 0, 1'b0);
         drain();
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random stalls, mostly short, a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(99) < 30) rsp_gap <= random_gap();
      end
   end

   // Check each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (class_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d class %0d count %0d",
                        rsp_data.kind, rsp_data.class_index, rsp_data.vote_count);
         end else begin
            e = class_queue.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.class_index !== e.class_index ||
                rsp_data.vote_count !== e.vote_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind %0d class %0d count %0d, got %0d %0d %0d",
                           e.kind, e.class_index, e.vote_count,
                           rsp_data.kind, rsp_data.class_index, rsp_data.vote_count);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      for (int l = 0; l < NUM_SLOTS; l++) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            bias_mem[l][i] = 0;
            for (int j = 0; j < MAX_NODES; j++) weight_mem[l][i][j] = 0;
         end
      end
      for (int i = 0; i < MAX_NODES; i++) feature_mem[i] = 0;
      for (int i = 0; i < MAX_CLASSES; i++) votes[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_wide_inputs();
      test_wide_outputs();
      test_two_hidden_wide();
      test_backpressure();
      test_random();
      if (mismatches == 0 && class_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
